### rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and constants of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned MaxResults = 3;

  // Parse modes
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_STR  = 3'd1;
  localparam logic [2:0] MODE_ESC  = 3'd2;
  localparam logic [2:0] MODE_HEX  = 3'd3;
  localparam logic [2:0] MODE_DONE = 3'd4;
  localparam logic [2:0] MODE_FAIL = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_EXP_STRING  = 3'd1;
  localparam logic [2:0] ERR_TRUNC_ESC   = 3'd2;
  localparam logic [2:0] ERR_TRUNC_UNI   = 3'd3;
  localparam logic [2:0] ERR_BAD_UNI     = 3'd4;
  localparam logic [2:0] ERR_BAD_ESC     = 3'd5;
  localparam logic [2:0] ERR_UNTERM      = 3'd6;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Cont  = 8'h80;
  localparam logic [7:0] Utf8Mask6 = 8'h3F;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  hex_cnt;
    logic [15:0] code_point;
    logic        hex_bad;
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] err;
  } result_t;

  localparam result_t ResultNone = '{data: 8'h00, kind: KIND_DATA, err: ERR_NONE};

  function automatic result_t data_res(input logic [7:0] b);
    result_t r;
    r      = ResultNone;
    r.data = b;
    return r;
  endfunction

  function automatic result_t err_res(input logic [2:0] e);
    result_t r;
    r      = ResultNone;
    r.kind = KIND_ERR;
    r.err  = e;
    return r;
  endfunction

endpackage

### rtl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Next-state and result logic for one text item.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  jsu_pkg::parse_state_t state_i,
  input  logic [7:0]            text_byte_i,
  input  logic                  end_of_text_i,
  output jsu_pkg::parse_state_t state_o,
  output logic [1:0]            n_res_o,
  output jsu_pkg::result_t      res_o [3]
);
  import jsu_pkg::*;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp_next;
  logic        blank;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (text_byte_i >= 8'h30 && text_byte_i <= 8'h39) begin
      hex_val = text_byte_i[3:0];
    end else if ((text_byte_i >= 8'h61 && text_byte_i <= 8'h66) ||
                 (text_byte_i >= 8'h41 && text_byte_i <= 8'h46)) begin
      hex_val = text_byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_next = {state_i.code_point[11:0], hex_val};
  assign blank   = (text_byte_i == 8'h20) || (text_byte_i == 8'h09) ||
                   (text_byte_i == 8'h0A) || (text_byte_i == 8'h0D);

  always_comb begin
    state_o = state_i;
    n_res_o = 2'd0;
    res_o[0] = ResultNone;
    res_o[1] = ResultNone;
    res_o[2] = ResultNone;

    if (end_of_text_i) begin
      state_o = '{mode: MODE_IDLE, hex_cnt: 2'd0, code_point: 16'd0, hex_bad: 1'b0};
      unique case (state_i.mode)
        MODE_IDLE: begin n_res_o = 2'd1; res_o[0] = err_res(ERR_EXP_STRING); end
        MODE_STR:  begin n_res_o = 2'd1; res_o[0] = err_res(ERR_UNTERM);     end
        MODE_ESC:  begin n_res_o = 2'd1; res_o[0] = err_res(ERR_TRUNC_ESC);  end
        MODE_HEX:  begin n_res_o = 2'd1; res_o[0] = err_res(ERR_TRUNC_UNI);  end
        default:   n_res_o = 2'd0;
      endcase
    end else begin
      unique case (state_i.mode)
        MODE_IDLE: begin
          if (text_byte_i == 8'h22) begin
            state_o.mode = MODE_STR;
          end else if (!blank) begin
            n_res_o      = 2'd1;
            res_o[0]     = err_res(ERR_EXP_STRING);
            state_o.mode = MODE_FAIL;
          end
        end
        MODE_STR: begin
          if (text_byte_i == 8'h22) begin
            n_res_o       = 2'd1;
            res_o[0]      = ResultNone;
            res_o[0].kind = KIND_DONE;
            state_o.mode  = MODE_DONE;
          end else if (text_byte_i == 8'h5C) begin
            state_o.mode = MODE_ESC;
          end else begin
            n_res_o  = 2'd1;
            res_o[0] = data_res(text_byte_i);
          end
        end
        MODE_ESC: begin
          state_o.mode = MODE_STR;
          n_res_o      = 2'd1;
          unique case (text_byte_i)
            8'h22, 8'h5C, 8'h2F: res_o[0] = data_res(text_byte_i);
            8'h62: res_o[0] = data_res(8'h08);
            8'h66: res_o[0] = data_res(8'h0C);
            8'h6E: res_o[0] = data_res(8'h0A);
            8'h72: res_o[0] = data_res(8'h0D);
            8'h74: res_o[0] = data_res(8'h09);
            8'h75: begin
              n_res_o            = 2'd0;
              state_o.mode       = MODE_HEX;
              state_o.hex_cnt    = 2'd0;
              state_o.code_point = 16'd0;
              state_o.hex_bad    = 1'b0;
            end
            default: begin
              res_o[0]     = err_res(ERR_BAD_ESC);
              state_o.mode = MODE_FAIL;
            end
          endcase
        end
        MODE_HEX: begin
          if (state_i.hex_cnt == 2'd3) begin
            state_o.hex_cnt    = 2'd0;
            state_o.code_point = 16'd0;
            state_o.hex_bad    = 1'b0;
            if (state_i.hex_bad || !hex_ok) begin
              n_res_o      = 2'd1;
              res_o[0]     = err_res(ERR_BAD_UNI);
              state_o.mode = MODE_FAIL;
            end else begin
              state_o.mode = MODE_STR;
              if (cp_next[15:7] == 9'd0) begin
                n_res_o  = 2'd1;
                res_o[0] = data_res({1'b0, cp_next[6:0]});
              end else if (cp_next[15:11] == 5'd0) begin
                n_res_o  = 2'd2;
                res_o[0] = data_res(Utf8Lead2 | {3'b000, cp_next[10:6]});
                res_o[1] = data_res(Utf8Cont | ({2'b00, cp_next[5:0]} & Utf8Mask6));
              end else begin
                n_res_o  = 2'd3;
                res_o[0] = data_res(Utf8Lead3 | {4'b0000, cp_next[15:12]});
                res_o[1] = data_res(Utf8Cont | {2'b00, cp_next[11:6]});
                res_o[2] = data_res(Utf8Cont | ({2'b00, cp_next[5:0]} & Utf8Mask6));
              end
            end
          end else begin
            state_o.hex_cnt    = state_i.hex_cnt + 2'd1;
            state_o.code_point = cp_next;
            state_o.hex_bad    = state_i.hex_bad | ~hex_ok;
          end
        end
        default: state_o = state_i; // done or failed: drop bytes
      endcase
    end
  end

endmodule

### rtl/jsu_result_buf.sv
// ----------------------------------------------------------------------------
// jsu_result_buf
// Three-entry shift buffer that serializes the results of one item.
// ----------------------------------------------------------------------------
module jsu_result_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [1:0]       load_cnt_i,
  input  jsu_pkg::result_t load_res_i [3],
  input  logic             pop_i,
  output jsu_pkg::result_t head_o,
  output logic [1:0]       cnt_o
);
  import jsu_pkg::*;

  result_t    ent_q [3];
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= load_cnt_i;
    end else if (pop_i) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q[0] <= load_res_i[0];
      ent_q[1] <= load_res_i[1];
      ent_q[2] <= load_res_i[2];
    end else if (pop_i) begin
      ent_q[0] <= ent_q[1];
      ent_q[1] <= ent_q[2];
    end
  end

  assign head_o = ent_q[0];
  assign cnt_o  = cnt_q;

endmodule

### rtl/json_string_unescaper.sv
// ----------------------------------------------------------------------------
// json_string_unescaper
// Decodes one JSON string literal from a byte stream into raw UTF-8 bytes.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake                | Payload
//  --------+-----+--------------------------+-----------------------------------------------
//  in      | in  | in_valid_i, in_stall_o   | text_byte_i, end_of_text_i
//  out     | out | out_valid_o, out_stall_i | out_byte_o, result_kind_o, error_code_o, last_of_run_o
//
//  Flow: an item lands in the input register, is decoded from there into the result
//  buffer, and its first result is shown from the head of that buffer.
//  One item per cycle while in_stall_o is low; an item with N results keeps the buffer
//  until its last result is taken, and the next item that gives results waits in the input register.
//  Reset: asynchronous, active low; parse state idle, both buffers empty. Stalls: an
//  output stall holds the result buffer, which holds the input register and raises
//  in_stall_o; items that give no result pass freely.
// ----------------------------------------------------------------------------
module json_string_unescaper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] result_kind_o,
  output logic [2:0] error_code_o,
  output logic       last_of_run_o
);
  import jsu_pkg::*;

  // Input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       eot_q;

  // Parse state
  parse_state_t state_q, state_d;

  logic       consume;
  logic       pop;
  logic       load;
  logic       can_load;
  logic [1:0] n_res;
  logic [1:0] buf_cnt;
  result_t    res [3];
  result_t    head;

  jsu_decode u_decode (
    .state_i       (state_q),
    .text_byte_i   (byte_q),
    .end_of_text_i (eot_q),
    .state_o       (state_d),
    .n_res_o       (n_res),
    .res_o         (res)
  );

  // Pop the head on a taken result; load a new run once the buffer drains.
  assign pop      = out_valid_o && !out_stall_i;
  assign can_load = (buf_cnt == 2'd0) || ((buf_cnt == 2'd1) && pop);
  assign consume  = in_valid_q && ((n_res == 2'd0) || can_load);
  assign load     = consume && (n_res != 2'd0);

  jsu_result_buf u_result_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .load_cnt_i (n_res),
    .load_res_i (res),
    .pop_i      (pop),
    .head_o     (head),
    .cnt_o      (buf_cnt)
  );

  // Hold the input register until its item is decoded.
  assign in_stall_o = in_valid_q && !consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= text_byte_i;
      eot_q  <= end_of_text_i;
    end
  end

  // Advance parse state once per decoded item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: MODE_IDLE, hex_cnt: 2'd0, code_point: 16'd0, hex_bad: 1'b0};
    end else if (consume) begin
      state_q <= state_d;
    end
  end

  assign out_valid_o   = (buf_cnt != 2'd0);
  assign out_byte_o    = head.data;
  assign result_kind_o = head.kind;
  assign error_code_o  = head.err;
  assign last_of_run_o = (buf_cnt == 2'd1);

  // Data results never carry an error code.
  a_data_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_DATA) |-> error_code_o == ERR_NONE)
    else $error("data result with error code");

  // Only multi-byte UTF-8 runs have results that are not last.
  a_run_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_run_o) |-> result_kind_o == KIND_DATA)
    else $error("non-data result inside a run");

  // A held input item stays in the register.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !consume) |=> (in_valid_q && $stable(byte_q) && $stable(eot_q)))
    else $error("input register lost a held item");

endmodule
